/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for tracker_row_to_midi_encoder, the RTL file that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/trme_pkg.sv */
// ----------------------------------------------------------------------------
// trme_pkg
// Types and constants of the tracker row to MIDI encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package trme_pkg;

  localparam logic [15:0] SPT_RESET    = 16'd5292;
  localparam int          PROD_W       = 24;

  localparam logic [7:0]  NOTE_NONE    = 8'd0;
  localparam logic [7:0]  NOTE_STOP    = 8'd254;
  localparam logic [7:0]  NOTE_OFF     = 8'd255;
  localparam logic [7:0]  VEL_USE_DEF  = 8'd255;
  localparam logic [7:0]  VEL_DEFAULT  = 8'h7f;
  localparam logic [7:0]  CHAN_KEEP    = 8'd255;
  localparam logic [7:0]  CMD_MIDI     = 8'd9;
  localparam logic [7:0]  PVAL_NONE    = 8'd128;
  localparam logic [7:0]  DATA_MAX     = 8'h7f;
  localparam logic [7:0]  MSG_BEND_MIN = 8'hfe;
  localparam logic [15:0] CVAL_NONE    = 16'hffff;

  localparam logic [13:0] PAR_NONE     = 14'h30ff;
  localparam logic [13:0] PAR_CC_BASE  = 14'h3000;
  localparam logic [13:0] PAR_CC_END   = 14'h30fb;
  localparam logic [13:0] PAR_BEND     = 14'h30fe;

  localparam logic [3:0]  KIND_OFF     = 4'h8;
  localparam logic [3:0]  KIND_ON      = 4'h9;
  localparam logic [3:0]  KIND_CC      = 4'hb;
  localparam logic [3:0]  KIND_BEND    = 4'he;

  // Message slots of one row, in emit order.
  typedef enum logic [1:0] {
    SLOT_PARAM,
    SLOT_CMD,
    SLOT_NOTE_OFF,
    SLOT_NOTE_ON
  } slot_t;

  localparam int NSLOT = 4;

  typedef struct packed {
    logic [7:0]  note_code;
    logic [7:0]  velocity_in;
    logic [7:0]  delay_fraction;
    logic [7:0]  command_code;
    logic [15:0] command_value;
    logic [13:0] parameter_code;
    logic [7:0]  parameter_value;
    logic [7:0]  channel_code;
  } row_t;

  typedef struct packed {
    logic [15:0] time_offset;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic        last_of_row;
  } midi_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
  } msg_t;

  typedef struct packed {
    logic [3:0] channel;
    logic [7:0] held_note;
    logic [3:0] held_channel;
  } voice_t;

  typedef struct packed {
    logic [NSLOT-1:0]       mask;
    msg_t [NSLOT-1:0]       slot;
  } decode_t;

endpackage

`default_nettype wire

/* rtl/trme_row_decode.sv */
// ----------------------------------------------------------------------------
// trme_row_decode
// Turns one tracker row and the voice state into up to four message slots
// and the voice state that follows the row.
// ----------------------------------------------------------------------------
`default_nettype none

module trme_row_decode import trme_pkg::*; (
  input  row_t    row,
  input  voice_t  voice,
  output decode_t dec,
  output voice_t  voice_next
);

  always_comb begin
    logic [3:0]  cur;
    logic [7:0]  vel;
    logic [7:0]  pclamp;
    logic [13:0] pdiff;
    logic [7:0]  cmsg;
    logic [7:0]  cval;
    logic [7:0]  cclamp;
    logic [7:0]  oct12;
    logic [7:0]  mnote;

    cur    = (row.channel_code != CHAN_KEEP) ? (row.channel_code[3:0] - 4'd1)
                                             : voice.channel;
    vel    = (row.velocity_in != VEL_USE_DEF) ? row.velocity_in : VEL_DEFAULT;
    pclamp = (row.parameter_value > DATA_MAX) ? DATA_MAX : row.parameter_value;
    pdiff  = row.parameter_code - PAR_CC_BASE;
    cmsg   = row.command_value[15:8];
    cval   = row.command_value[7:0];
    cclamp = (cval > DATA_MAX) ? DATA_MAX : cval;
    // 12 * octave as 8x + 4x
    oct12  = {1'b0, row.note_code[7:4], 3'b000} + {2'b00, row.note_code[7:4], 2'b00};
    mnote  = oct12 + {4'b0000, row.note_code[3:0]} - 8'd1;

    dec        = '0;
    voice_next = voice;
    voice_next.channel = cur;

    if (row.parameter_code != PAR_NONE && row.parameter_value != PVAL_NONE) begin
      if (row.parameter_code >= PAR_CC_BASE && row.parameter_code < PAR_CC_END) begin
        dec.mask[SLOT_PARAM] = 1'b1;
        dec.slot[SLOT_PARAM] = '{status_byte: {KIND_CC, cur},
                                 first_data:  pdiff[7:0],
                                 second_data: pclamp};
      end else if (row.parameter_code == PAR_BEND) begin
        dec.mask[SLOT_PARAM] = 1'b1;
        dec.slot[SLOT_PARAM] = '{status_byte: {KIND_BEND, cur},
                                 first_data:  pclamp,
                                 second_data: 8'd0};
      end
    end

    if (row.command_code == CMD_MIDI && row.command_value != CVAL_NONE) begin
      if (cmsg <= DATA_MAX) begin
        dec.mask[SLOT_CMD] = 1'b1;
        dec.slot[SLOT_CMD] = '{status_byte: {KIND_CC, cur},
                               first_data:  cmsg,
                               second_data: cclamp};
      end else if (cmsg >= MSG_BEND_MIN) begin
        dec.mask[SLOT_CMD] = 1'b1;
        dec.slot[SLOT_CMD] = '{status_byte: {KIND_BEND, cur},
                               first_data:  cmsg,
                               second_data: cval};
      end
    end

    if (row.note_code != NOTE_NONE) begin
      if (voice.held_note != NOTE_NONE) begin
        dec.mask[SLOT_NOTE_OFF] = 1'b1;
        dec.slot[SLOT_NOTE_OFF] = '{status_byte: {KIND_OFF, voice.held_channel},
                                    first_data:  voice.held_note,
                                    second_data: 8'd0};
        voice_next.held_note = NOTE_NONE;
      end
      if (row.note_code != NOTE_STOP && row.note_code != NOTE_OFF) begin
        dec.mask[SLOT_NOTE_ON] = 1'b1;
        dec.slot[SLOT_NOTE_ON] = '{status_byte: {KIND_ON, cur},
                                   first_data:  mnote,
                                   second_data: vel};
        voice_next.held_note    = mnote;
        voice_next.held_channel = cur;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tracker_row_to_midi_encoder.sv */
// An accepted row waits in the pending slots until its messages are loaded into msg.
// Throughput: one row per cycle when it yields at most one message and msg does not
// stall; otherwise one message at a time through the single message output register
// (at most 4 per row). Rows with no message are taken every cycle and make no beat.
// Synchronous reset: tick length 5292, channel 0, no held note, no pending beats.
// ----------------------------------------------------------------------------
// tracker_row_to_midi_encoder
// Decodes tracker rows into parameter, command, note-off and note-on MIDI
// messages, each stamped with floor(tick length * delay / 255).
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tracker_row_to_midi_encoder import trme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        row_valid,
  output logic        row_ready,
  input  row_t        row,
  output logic        msg_valid,
  input  logic        msg_ready,
  output midi_t       msg
);

  logic [15:0]       tick_samples;
  voice_t            voice;
  voice_t            voice_next;
  decode_t           dec;
  logic [NSLOT-1:0]  pend;
  logic [NSLOT-1:0]  pend_next;
  msg_t [NSLOT-1:0]  slot_msg;
  logic [PROD_W-1:0] prod;
  logic              row_take;
  logic              msg_load;
  slot_t             sel;
  logic [NSLOT-1:0]  remain;
  logic [16:0]       q_est;
  logic [24:0]       q255;
  logic [24:0]       rem_full;
  logic [9:0]        rem;
  logic [1:0]        corr;
  logic [16:0]       quot;
  logic              row_stop;

  trme_row_decode u_decode (
    .row        (row),
    .voice      (voice),
    .dec        (dec),
    .voice_next (voice_next)
  );

  // earliest pending slot goes out first
  always_comb begin
    priority if (pend[SLOT_PARAM])    sel = SLOT_PARAM;
    else if (pend[SLOT_CMD])          sel = SLOT_CMD;
    else if (pend[SLOT_NOTE_OFF])     sel = SLOT_NOTE_OFF;
    else                              sel = SLOT_NOTE_ON;
  end

  always_comb begin
    remain      = pend;
    remain[sel] = 1'b0;
  end

  assign msg_load  = (|pend) && (!msg_valid || msg_ready);
  assign row_ready = !(|pend) || (msg_load && !(|remain));
  assign row_take  = row_valid && row_ready;
  assign row_stop  = (row.note_code == NOTE_STOP) || (row.note_code == NOTE_OFF);

  always_comb begin
    pend_next = pend;
    if (msg_load) begin
      pend_next = remain;
    end
    if (row_take) begin
      pend_next = dec.mask;
    end
  end

  // prod / 255: estimate from prod/256 + prod/65536, then fix up by at most 3
  always_comb begin
    q_est    = {1'b0, prod[23:8]} + {9'b0, prod[23:16]};
    q255     = {q_est, 8'b0} - {8'b0, q_est};
    rem_full = {1'b0, prod} - q255;
    rem      = rem_full[9:0];
    priority if (rem >= 10'd765) corr = 2'd3;
    else if (rem >= 10'd510)     corr = 2'd2;
    else if (rem >= 10'd255)     corr = 2'd1;
    else                         corr = 2'd0;
    quot     = q_est + {15'b0, corr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_samples <= SPT_RESET;
      voice        <= '0;
      pend         <= '0;
      msg_valid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        tick_samples <= cfg_wdata;
      end
      if (row_take) begin
        voice <= voice_next;
      end
      pend <= pend_next;
      if (msg_load) begin
        msg_valid <= 1'b1;
      end else if (msg_ready) begin
        msg_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_take) begin
      slot_msg <= dec.slot;
      prod     <= {8'b0, tick_samples} * {16'b0, row.delay_fraction};
    end
    if (msg_load) begin
      msg.time_offset <= quot[15:0];
      msg.status_byte <= slot_msg[sel].status_byte;
      msg.first_data  <= slot_msg[sel].first_data;
      msg.second_data <= slot_msg[sel].second_data;
      msg.last_of_row <= !(|remain);
    end
  end

  `ASSERT_CLK(a_busy_blocks, ((pend & (pend - 4'd1)) != 4'd0) |-> !row_ready, "mid-row take")
  `ASSERT_CLK(a_row_fills_slots, (row_take && (|dec.mask)) |=> (|pend), "row left no beats")
  `ASSERT_NEVER(a_tail_kept, msg_valid && !msg.last_of_row && !(|pend), "row tail lost")
  `ASSERT_CLK(a_stop_clears, (row_take && row_stop) |=> (voice.held_note == NOTE_NONE), "note held")

endmodule

`default_nettype wire
